// ----- rtl/core/memory_map_range_classifier_top_assert.svh -----
// assertion macros for the memory map range classifier
// used by memory_map_range_classifier_top, no other dependencies
`ifndef MEMORY_MAP_RANGE_CLASSIFIER_TOP_ASSERT_SVH
`define MEMORY_MAP_RANGE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MMRC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("mmrc same-cycle check failed");

// next-cycle implication, checked outside reset
`define MMRC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("mmrc next-cycle check failed");

`endif

// ----- rtl/core/mmrc_pkg.sv -----
// shared types and constants for the memory map range classifier
// no dependencies
`default_nettype none

package mmrc_pkg;

  localparam logic [63:0] ONE_MIB        = 64'h0000_0000_0010_0000;
  localparam logic [31:0] APIC_BASE_RST  = 32'hFEE0_0000;

  localparam logic [31:0] KIND_RAM       = 32'd1;
  localparam logic [31:0] KIND_RESERVED  = 32'd2;
  localparam logic [31:0] KIND_ACPI      = 32'd3;

  localparam logic CLASS_SYSTEM   = 1'b0;
  localparam logic CLASS_RESERVED = 1'b1;

  // decoded entry kind
  typedef enum logic [1:0] {
    KC_NONE,
    KC_RAM,
    KC_ACPI,
    KC_WINDOW
  } kind_code_t;

  // one queued entry: one or two ranges
  typedef struct packed {
    logic [63:0] r0_start;
    logic [63:0] r0_stop;
    logic [63:0] r1_start;
    logic [63:0] r1_stop;
    logic        r0_class;
    logic        has_second;
  } mmrc_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mmrc_qstat_t;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/memory_map_range_classifier_top.sv -----
// top level of the memory map range classifier: window register, front, queue, back
// depends on mmrc_pkg, mmrc_front, mmrc_queue, mmrc_back and the assertion header
//
// channel  | direction | handshake        | payload
// in_      | input     | valid / stall    | entry_base, entry_length, entry_kind
// out_     | output    | valid / stall    | range_start, range_stop, range_class, final_of_entry
// cfg_     | input     | valid / ready    | apic_window_base
//
// one entry accepted per cycle while in_stall is low; an entry that yields
// two ranges holds the output for two transfers, so the rate there is set by
// the output register; the first range passes through three registers
// (input stage, queue, output reg)
// rst_n is synchronous; it empties every stage and sets the window base to 0xFEE00000
// out_stall freezes a valid output register; behind it the queue and the input stage
// hold QUEUE_DEPTH + 1 entries that yield ranges before in_stall rises
`default_nettype none

`include "memory_map_range_classifier_top_assert.svh"

module memory_map_range_classifier_top #(
  parameter int PAGE_SHIFT_BITS = 12,
  parameter int QUEUE_DEPTH     = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_entry_base,
  input  wire logic [63:0] in_entry_length,
  input  wire logic [31:0] in_entry_kind,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_range_start,
  output logic [63:0]      out_range_stop,
  output logic             out_range_class,
  output logic             out_final_of_entry,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_apic_window_base
);
  import mmrc_pkg::*;

  logic [31:0] apic_base_r, apic_base_nxt;
  mmrc_qstat_t q_stat;
  mmrc_entry_t q_entry, q_head;
  logic        q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    apic_base_nxt = (cfg_valid && cfg_ready) ? cfg_apic_window_base : apic_base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apic_base_r <= APIC_BASE_RST;
    end else begin
      apic_base_r <= apic_base_nxt;
    end
  end

  mmrc_front #(
    .PAGE_SHIFT_BITS(PAGE_SHIFT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_entry_base   (in_entry_base),
    .in_entry_length (in_entry_length),
    .in_entry_kind   (in_entry_kind),
    .apic_base       (apic_base_r),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  mmrc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  mmrc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_range_start    (out_range_start),
    .out_range_stop     (out_range_stop),
    .out_range_class    (out_range_class),
    .out_final_of_entry (out_final_of_entry)
  );

  // input only backs up when the queue is full
  `MMRC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, q_stat.full)
  // never push into a full queue
  `MMRC_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !q_stat.full)
  // only window splits give a first range that is not final
  `MMRC_ASSERT_NOW(a_split_is_reserved, clk, rst_n, out_valid && !out_final_of_entry,
                   out_range_class == CLASS_RESERVED)
  // second range of a split follows its first right after the transfer
  `MMRC_ASSERT_NEXT(a_second_follows, clk, rst_n,
                    out_valid && !out_final_of_entry && !out_stall, out_valid)

endmodule

`default_nettype wire

// ----- rtl/core/mmrc_front.sv -----
// front end: page rounding of the entry, window split, queue push
// depends on mmrc_pkg
`default_nettype none

module mmrc_front #(
  parameter int PAGE_SHIFT_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [63:0]          in_entry_base,
  input  wire logic [63:0]          in_entry_length,
  input  wire logic [31:0]          in_entry_kind,
  input  wire logic [31:0]          apic_base,
  input  wire mmrc_pkg::mmrc_qstat_t q_stat,
  output logic                      q_push,
  output mmrc_pkg::mmrc_entry_t     q_entry
);
  import mmrc_pkg::*;

  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT_BITS) - 64'd1;

  logic        s1_valid_r, s1_valid_nxt;
  logic [63:0] s1_start_r, s1_stop_r;
  kind_code_t  s1_kind_r, kind_dec;

  logic [63:0] start_al, start_cl, stop_al;
  logic        accept, s1_emit, s1_blocked;

  logic [63:0] win_lo, win_hi, lo_end, hi_beg;
  logic        ok, lo_ok, hi_ok;

  // stage 1: rounding
  always_comb begin
    start_al = (in_entry_base + PAGE_MASK) & ~PAGE_MASK;
    start_cl = (start_al < ONE_MIB) ? ONE_MIB : start_al;
    stop_al  = (in_entry_base + in_entry_length) & ~PAGE_MASK;
    case (in_entry_kind)
      KIND_RAM:      kind_dec = KC_RAM;
      KIND_RESERVED: kind_dec = KC_WINDOW;
      KIND_ACPI:     kind_dec = KC_ACPI;
      default:       kind_dec = KC_NONE;
    endcase
  end

  // stage 2: compares and split, all in parallel
  always_comb begin
    win_lo = {32'd0, apic_base};
    win_hi = {32'd0, apic_base} + ONE_MIB;
    ok     = s1_start_r < s1_stop_r;
    lo_ok  = ok && (s1_start_r < win_lo);
    hi_ok  = ok && (win_hi < s1_stop_r);
    lo_end = (s1_stop_r < win_lo) ? s1_stop_r : win_lo;
    hi_beg = (s1_start_r > win_hi) ? s1_start_r : win_hi;

    q_entry.r1_start   = hi_beg;
    q_entry.r1_stop    = s1_stop_r;
    q_entry.r0_start   = s1_start_r;
    q_entry.r0_stop    = s1_stop_r;
    q_entry.r0_class   = CLASS_RESERVED;
    q_entry.has_second = 1'b0;
    s1_emit            = 1'b0;
    case (s1_kind_r)
      KC_RAM: begin
        q_entry.r0_class = CLASS_SYSTEM;
        s1_emit          = ok;
      end
      KC_ACPI: begin
        s1_emit = ok;
      end
      KC_WINDOW: begin
        s1_emit = lo_ok || hi_ok;
        if (lo_ok) begin
          q_entry.r0_stop    = lo_end;
          q_entry.has_second = hi_ok;
        end else begin
          q_entry.r0_start = hi_beg;
        end
      end
      default: s1_emit = 1'b0;
    endcase
  end

  assign s1_blocked = s1_valid_r && s1_emit && q_stat.full;
  assign in_stall   = s1_blocked;
  assign accept     = in_valid && !s1_blocked;
  assign q_push     = s1_valid_r && s1_emit && !q_stat.full;

  always_comb begin
    s1_valid_nxt = s1_blocked ? 1'b1 : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start_r <= start_cl;
      s1_stop_r  <= stop_al;
      s1_kind_r  <= kind_dec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmrc_queue.sv -----
// small entry queue between front and back end
// depends on mmrc_pkg
`default_nettype none

module mmrc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire mmrc_pkg::mmrc_entry_t push_entry,
  input  wire logic                  pop,
  output mmrc_pkg::mmrc_entry_t      head,
  output mmrc_pkg::mmrc_qstat_t      stat
);
  import mmrc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmrc_entry_t   mem_r [DEPTH];
  mmrc_entry_t   head_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  assign head       = head_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
    // head copy follows the read pointer, the entry written this cycle passes through
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_entry;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmrc_back.sv -----
// back end: walks each queued entry out one range per transfer
// depends on mmrc_pkg
`default_nettype none

module mmrc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mmrc_pkg::mmrc_entry_t head,
  input  wire mmrc_pkg::mmrc_qstat_t q_stat,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [63:0]                out_range_start,
  output logic [63:0]                out_range_stop,
  output logic                       out_range_class,
  output logic                       out_final_of_entry
);
  import mmrc_pkg::*;

  back_state_t state_r, state_nxt;
  logic        valid_r, valid_nxt;
  logic [63:0] start_r, start_nxt, stop_r, stop_nxt;
  logic        class_r, class_nxt, final_r, final_nxt;
  logic        load;

  // output register can take a new range when empty or being drained
  assign load = !valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    class_nxt = class_r;
    final_nxt = final_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        class_nxt = head.r0_class;
        case (state_r)
          BK_FIRST: begin
            start_nxt = head.r0_start;
            stop_nxt  = head.r0_stop;
            if (head.has_second) begin
              final_nxt = 1'b0;
              state_nxt = BK_SECOND;
            end else begin
              final_nxt = 1'b1;
              q_pop     = 1'b1;
            end
          end
          BK_SECOND: begin
            start_nxt = head.r1_start;
            stop_nxt  = head.r1_stop;
            final_nxt = 1'b1;
            q_pop     = 1'b1;
            state_nxt = BK_FIRST;
          end
          default: state_nxt = BK_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_FIRST;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    class_r <= class_nxt;
    final_r <= final_nxt;
  end

  assign out_valid          = valid_r;
  assign out_range_start    = start_r;
  assign out_range_stop     = stop_r;
  assign out_range_class    = class_r;
  assign out_final_of_entry = final_r;

endmodule

`default_nettype wire
